// ===== hdl/rc5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared constants and the frame coding function of the rc5 transmitter.
// ----------------------------------------------------------------------------
package rc5_pkg;

    // frame geometry
    localparam int FRAME_BITS = 14;
    localparam int HALF_BITS  = 2 * FRAME_BITS;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = $clog2(HALF_BITS);

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [HALF_BITS-1:0]  half_word_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [1:0]            op_t;

    // operation codes
    localparam op_t OP_TICK = 2'd0;
    localparam op_t OP_SEND = 2'd1;
    localparam op_t OP_RAW  = 2'd2;

    // frame bits and masks
    localparam frame_t START_BIT  = 14'h2000;
    localparam frame_t FIELD_BIT  = 14'h1000;
    localparam frame_t TOGGLE_BIT = 14'h0800;
    localparam frame_t CMD_MASK   = 14'h003F;
    localparam logic [1:0] HALF_ONE  = 2'h2;
    localparam logic [1:0] HALF_ZERO = 2'h1;

    // last usable count value, so the counter can still pass it
    localparam count_t COUNT_LIMIT = 8'd254;

    // manchester coding: half-bit k goes out on tick k, frame msb first,
    // a one goes out as carrier off then on
    function automatic half_word_t encode_frame(input frame_t frame);
        half_word_t word;
        word = '0;
        for (int k = 0; k < FRAME_BITS; k++)
        begin
            word[2*k +: 2] = frame[FRAME_BITS-1-k] ? HALF_ONE : HALF_ZERO;
        end
        return word;
    endfunction

endpackage

// ===== hdl/rc5_ir_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_ir_transmitter
// Extended RC5 infrared transmitter: builds and manchester codes a frame,
// then gives one half-bit carrier enable on each timer tick.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   op, address, command, toggle,
//                                             raw_frame
// out       output     out_valid / out_stall carrier_on, busy_res, accepted
// cfg       input      cfg_valid / cfg_ready cfg_data (frame_half_bits)
//
// One item per cycle while in_stall is low; its result is registered. The
// state update and result logic is a single combinational pass from the
// state registers. An output register plus a skid entry let the input keep
// flowing while a result waits; in_stall rises only when both are full.
// Reset clears the state and sets frame_half_bits to 128.
// ----------------------------------------------------------------------------
module rc5_ir_transmitter
    import rc5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  address,
    input  logic [6:0]  command,
    input  logic        toggle,
    input  logic [13:0] raw_frame,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        carrier_on,
    output logic        busy_res,
    output logic        accepted,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic accepted;
    } result_t;

    // transmitter state
    count_t     frame_half_bits_reg;
    half_word_t manchester_word_reg, manchester_word_next;
    count_t     half_bit_count_reg, half_bit_count_next;
    logic       frame_ready_reg, frame_ready_next;
    logic       send_done_reg, send_done_next;
    logic       carrier_level_reg, carrier_level_next;

    // output buffering
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    logic    in_xfer;
    logic    out_xfer;
    logic    busy;
    count_t  last_index;
    frame_t  frame;
    logic    accepted_now;
    result_t result;

    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_half_bits_reg <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_half_bits_reg <= cfg_data;
        end
    end

    // frame packing for both send kinds
    always_comb
    begin
        if (op == OP_SEND)
        begin
            frame = START_BIT | (command[6] ? '0 : FIELD_BIT)
                  | (toggle ? TOGGLE_BIT : '0)
                  | (frame_t'(address) << 6)
                  | (frame_t'(command) & CMD_MASK);
        end
        else
        begin
            frame = raw_frame | START_BIT;
        end
    end

    // next state and result for one item
    always_comb
    begin
        manchester_word_next = manchester_word_reg;
        half_bit_count_next  = half_bit_count_reg;
        frame_ready_next     = frame_ready_reg;
        send_done_next       = send_done_reg;
        carrier_level_next   = carrier_level_reg;
        accepted_now         = 1'b0;
        busy                 = frame_ready_reg || !send_done_reg;
        last_index           = (frame_half_bits_reg > COUNT_LIMIT) ? COUNT_LIMIT
                                                                    : frame_half_bits_reg;
        case (op)
            OP_TICK:
            begin
                if (frame_ready_reg && half_bit_count_reg <= last_index)
                begin
                    send_done_next = 1'b0;
                    // idle gap after the coded half-bits is carrier off
                    if (half_bit_count_reg < count_t'(HALF_BITS))
                    begin
                        carrier_level_next =
                            manchester_word_reg[half_bit_count_reg[IDX_W-1:0]];
                    end
                    else
                    begin
                        carrier_level_next = 1'b0;
                    end
                    half_bit_count_next = half_bit_count_reg + 8'd1;
                end
                else
                begin
                    // end of send, or tick while idle
                    send_done_next      = 1'b1;
                    carrier_level_next  = 1'b0;
                    frame_ready_next    = 1'b0;
                    half_bit_count_next = '0;
                end
            end
            OP_SEND, OP_RAW:
            begin
                if (!busy)
                begin
                    manchester_word_next = encode_frame(frame);
                    half_bit_count_next  = '0;
                    frame_ready_next     = 1'b1;
                    accepted_now         = 1'b1;
                end
            end
            default:
            begin
                accepted_now = 1'b0;
            end
        endcase
        result.carrier_on = carrier_level_next;
        result.busy_res   = frame_ready_next || !send_done_next;
        result.accepted   = accepted_now;
    end

    // state registers, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manchester_word_reg <= '0;
            half_bit_count_reg  <= '0;
            frame_ready_reg     <= 1'b0;
            send_done_reg       <= 1'b1;
            carrier_level_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            manchester_word_reg <= manchester_word_next;
            half_bit_count_reg  <= half_bit_count_next;
            frame_ready_reg     <= frame_ready_next;
            send_done_reg       <= send_done_next;
            carrier_level_reg   <= carrier_level_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrier_on = out_data_reg.carrier_on;
    assign busy_res   = out_data_reg.busy_res;
    assign accepted   = out_data_reg.accepted;

    // skid entry fills only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // counter sits at zero whenever no frame is loaded
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_ready_reg |-> (half_bit_count_reg == '0))
        else $error("half-bit count nonzero without a loaded frame");

    // carrier is only driven during a send
    a_carrier_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        carrier_level_reg |-> frame_ready_reg)
        else $error("carrier on outside of a send");

    // an accepted send always reports busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && accepted_now) |=> frame_ready_reg)
        else $error("accepted send did not load a frame");

endmodule
